>>> sv/swms_pkg.sv
// Package: widths, register codes, command codes and the controller command struct.
package swms_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int DELAY_DEPTH = 4096;
	localparam int ADDR_W      = $clog2(DELAY_DEPTH);
	localparam int FRAC_W      = 8;
	localparam int POS_W       = ADDR_W + FRAC_W;

	localparam int COEF_W      = 16;
	localparam int GAIN_W      = 16;
	localparam int MIX_W       = 15;
	localparam int DELAY_W     = 20;
	localparam int CFG_W       = 20;
	localparam int CFG_IDX_W   = 2;

	localparam int SIDE_W         = SAMPLE_BITS + 1;
	localparam int LP_IN_SHIFT    = 7;
	localparam int LP_W           = SIDE_W + LP_IN_SHIFT;
	localparam int LP_SHIFT       = 16;
	localparam int LP_ACC_SHIFT   = 17;
	localparam int GAIN_ACC_SHIFT = 10;
	localparam int MID_SHIFT      = 24;
	localparam int OUT_SHIFT      = 25;

	localparam int MA_W   = LP_W + 1;
	localparam int MB_W   = 17;
	localparam int PROD_W = MA_W + MB_W;
	localparam int ACC_W  = SAMPLE_BITS + 30;

	localparam int IN_DATA_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8;

	localparam logic [COEF_W-1:0]  LOWPASS_COEF_RST = COEF_W'(1274);
	localparam logic [GAIN_W-1:0]  WIDTH_GAIN_RST   = GAIN_W'(24576);
	localparam logic [MIX_W-1:0]   HAAS_MIX_RST     = MIX_W'(9830);
	localparam logic [DELAY_W-1:0] DELAY_AMOUNT_RST = DELAY_W'(61440);

	localparam logic [CFG_IDX_W-1:0] REG_LOWPASS_COEF = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH_GAIN   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HAAS_MIX     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DELAY_AMOUNT = 2'd3;

	localparam logic [1:0] MUL_LP     = 2'd0;
	localparam logic [1:0] MUL_GAIN   = 2'd1;
	localparam logic [1:0] MUL_INTERP = 2'd2;
	localparam logic [1:0] MUL_MIX    = 2'd3;

	localparam logic [1:0] ACC_HOLD = 2'd0;
	localparam logic [1:0] ACC_INIT = 2'd1;
	localparam logic [1:0] ACC_GAIN = 2'd2;
	localparam logic [1:0] ACC_MIX  = 2'd3;

	localparam logic RD_I0 = 1'b0;
	localparam logic RD_I1 = 1'b1;

	typedef struct packed {
		logic              load_in;
		logic              mul_en;
		logic [1:0]        mul_sel;
		logic              lp_upd;
		logic              high_wr;
		logic              rd_en;
		logic              rd_sel;
		logic              s0_cap;
		logic [1:0]        acc_op;
		logic              out_load;
		logic              clr_wr;
		logic [ADDR_W-1:0] clr_addr;
	} cmd_t;

endpackage

>>> sv/swms_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module swms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> sv/swms_ctrl.sv
// Controller: delay-line clear sweep, per-item step sequence and output handshake.
module swms_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  logic               m_tready,
	output swms_pkg::cmd_t     cmd
);

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_MLP   = 4'd2;
	localparam logic [3:0] ST_LPU   = 4'd3;
	localparam logic [3:0] ST_HIGH  = 4'd4;
	localparam logic [3:0] ST_RD0   = 4'd5;
	localparam logic [3:0] ST_RD1   = 4'd6;
	localparam logic [3:0] ST_MINT  = 4'd7;
	localparam logic [3:0] ST_MMIX  = 4'd8;
	localparam logic [3:0] ST_ACC   = 4'd9;
	localparam logic [3:0] ST_OUT   = 4'd10;

	logic [3:0]                  state_q, state_d;
	logic [swms_pkg::ADDR_W-1:0] clr_q;
	logic                        out_valid_q;
	logic                        out_free;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.clr_addr = clr_q;
		cmd.acc_op   = swms_pkg::ACC_HOLD;
		cmd.mul_sel  = swms_pkg::MUL_LP;
		cmd.rd_sel   = swms_pkg::RD_I0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (clr_q == swms_pkg::ADDR_W'(swms_pkg::DELAY_DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_MLP;
				end
			end
			ST_MLP: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = swms_pkg::MUL_LP;
				state_d     = ST_LPU;
			end
			ST_LPU: begin
				cmd.lp_upd = 1'b1;
				state_d    = ST_HIGH;
			end
			ST_HIGH: begin
				cmd.high_wr = 1'b1;
				cmd.acc_op  = swms_pkg::ACC_INIT;
				state_d     = ST_RD0;
			end
			ST_RD0: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_sel  = swms_pkg::RD_I0;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = swms_pkg::MUL_GAIN;
				state_d     = ST_RD1;
			end
			ST_RD1: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = swms_pkg::RD_I1;
				cmd.s0_cap = 1'b1;
				cmd.acc_op = swms_pkg::ACC_GAIN;
				state_d    = ST_MINT;
			end
			ST_MINT: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = swms_pkg::MUL_INTERP;
				state_d     = ST_MMIX;
			end
			ST_MMIX: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = swms_pkg::MUL_MIX;
				state_d     = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc_op = swms_pkg::ACC_MIX;
				state_d    = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.clr_wr) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> sv/swms_datapath.sv
// Datapath: config registers, shared multiplier, lowpass, delay line and output rounding.
module swms_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [swms_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [swms_pkg::CFG_W-1:0]           cfg_wdata,
	input  logic signed [swms_pkg::SAMPLE_BITS-1:0] left_in,
	input  logic signed [swms_pkg::SAMPLE_BITS-1:0] right_in,
	input  swms_pkg::cmd_t                       cmd,
	output logic signed [swms_pkg::SAMPLE_BITS-1:0] left_out,
	output logic signed [swms_pkg::SAMPLE_BITS-1:0] right_out,
	output logic                                 clipped
);

	localparam int SW    = swms_pkg::SAMPLE_BITS;
	localparam int SDW   = swms_pkg::SIDE_W;
	localparam int LPW   = swms_pkg::LP_W;
	localparam int MAW   = swms_pkg::MA_W;
	localparam int MBW   = swms_pkg::MB_W;
	localparam int PW    = swms_pkg::PROD_W;
	localparam int AW    = swms_pkg::ACC_W;
	localparam int ADW   = swms_pkg::ADDR_W;
	localparam int FW    = swms_pkg::FRAC_W;
	localparam int PSW   = swms_pkg::POS_W;
	localparam int OSH   = swms_pkg::OUT_SHIFT;
	localparam int SUMW  = AW - OSH;

	logic [swms_pkg::COEF_W-1:0]  coef_q;
	logic [swms_pkg::GAIN_W-1:0]  gain_q;
	logic [swms_pkg::MIX_W-1:0]   mix_q;
	logic [swms_pkg::DELAY_W-1:0] delay_q;

	logic signed [SDW-1:0] d_q, m_q, high_q, s0_q;
	logic signed [LPW-1:0] lp_q;
	logic signed [PW-1:0]  prod_q;
	logic signed [AW-1:0]  acc_q;
	logic [ADW-1:0]        wi_q;
	logic [PSW-1:0]        pos_q;

	logic signed [LPW-1:0] target;
	logic signed [MAW-1:0] diff;
	logic signed [MAW-1:0] mul_a;
	logic signed [MBW-1:0] mul_b;
	logic signed [PW-1:0]  prod_d;
	logic signed [SDW:0]   delta;
	logic signed [MAW-1:0] dl;
	logic signed [SDW:0]   hdiff;
	logic signed [SDW-1:0] high_d;
	logic signed [SDW-1:0] ram_rdata;
	logic                  ram_we;
	logic [ADW-1:0]        ram_waddr, ram_raddr, i0;
	logic [SDW-1:0]        ram_wdata;
	logic signed [AW-1:0]  mid_ext, sum_l, sum_r;
	logic [SUMW-1:0]       top_l, top_r;
	logic                  ovf_l, ovf_r;
	logic signed [SW-1:0]  sat_l, sat_r;

	localparam logic signed [AW-1:0] ROUND = AW'(1) <<< (OSH - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q  <= swms_pkg::LOWPASS_COEF_RST;
			gain_q  <= swms_pkg::WIDTH_GAIN_RST;
			mix_q   <= swms_pkg::HAAS_MIX_RST;
			delay_q <= swms_pkg::DELAY_AMOUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				swms_pkg::REG_LOWPASS_COEF: coef_q  <= cfg_wdata[swms_pkg::COEF_W-1:0];
				swms_pkg::REG_WIDTH_GAIN:   gain_q  <= cfg_wdata[swms_pkg::GAIN_W-1:0];
				swms_pkg::REG_HAAS_MIX:     mix_q   <= cfg_wdata[swms_pkg::MIX_W-1:0];
				swms_pkg::REG_DELAY_AMOUNT: delay_q <= cfg_wdata[swms_pkg::DELAY_W-1:0];
			endcase
		end
	end

	assign target = {d_q, {swms_pkg::LP_IN_SHIFT{1'b0}}};
	assign diff   = $signed({target[LPW-1], target}) - $signed({lp_q[LPW-1], lp_q});
	assign delta  = $signed({ram_rdata[SDW-1], ram_rdata}) - $signed({s0_q[SDW-1], s0_q});
	assign dl     = $signed({s0_q, {FW{1'b0}}}) + $signed(prod_q[MAW-1:0]);

	always_comb begin
		mul_a = diff;
		mul_b = $signed({1'b0, coef_q});
		unique case (cmd.mul_sel)
			swms_pkg::MUL_LP: begin
				mul_a = diff;
				mul_b = $signed({1'b0, coef_q});
			end
			swms_pkg::MUL_GAIN: begin
				mul_a = $signed({{(MAW-SDW){high_q[SDW-1]}}, high_q});
				mul_b = $signed({1'b0, gain_q});
			end
			swms_pkg::MUL_INTERP: begin
				mul_a = $signed({{(MAW-SDW-1){delta[SDW]}}, delta});
				mul_b = $signed({{(MBW-FW){1'b0}}, pos_q[FW-1:0]});
			end
			swms_pkg::MUL_MIX: begin
				mul_a = dl;
				mul_b = $signed({{(MBW-swms_pkg::MIX_W){1'b0}}, mix_q});
			end
		endcase
	end

	assign prod_d = mul_a * mul_b;

	// high band = d - floor(lp / 128), saturated
	assign hdiff  = $signed({d_q[SDW-1], d_q})
		- $signed({lp_q[LPW-1], lp_q[LPW-1:swms_pkg::LP_IN_SHIFT]});
	assign high_d = (hdiff[SDW] != hdiff[SDW-1])
		? $signed({hdiff[SDW], {(SDW-1){~hdiff[SDW]}}}) : hdiff[SDW-1:0];

	assign i0        = pos_q[PSW-1:FW];
	assign ram_raddr = (cmd.rd_sel == swms_pkg::RD_I1) ? i0 + 1'b1 : i0;
	assign ram_we    = cmd.clr_wr || cmd.high_wr;
	assign ram_waddr = cmd.clr_wr ? cmd.clr_addr : wi_q;
	assign ram_wdata = cmd.clr_wr ? '0 : high_d;

	swms_ram #(
		.WIDTH(SDW),
		.DEPTH(swms_pkg::DELAY_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.rd_en),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lp_q <= '0;
			wi_q <= '0;
		end else begin
			if (cmd.lp_upd) begin
				lp_q <= lp_q + $signed(prod_q[swms_pkg::LP_SHIFT+LPW-1:swms_pkg::LP_SHIFT]);
			end
			if (cmd.high_wr) begin
				wi_q <= wi_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			d_q <= $signed({left_in[SW-1], left_in}) - $signed({right_in[SW-1], right_in});
			m_q <= $signed({left_in[SW-1], left_in}) + $signed({right_in[SW-1], right_in});
		end
		if (cmd.mul_en) begin
			prod_q <= prod_d;
		end
		if (cmd.high_wr) begin
			high_q <= high_d;
			pos_q  <= {wi_q, {FW{1'b0}}} - delay_q[PSW-1:0];
		end
		if (cmd.s0_cap) begin
			s0_q <= ram_rdata;
		end
		unique case (cmd.acc_op)
			swms_pkg::ACC_HOLD: acc_q <= acc_q;
			swms_pkg::ACC_INIT: acc_q <= $signed({{(AW-LPW-swms_pkg::LP_ACC_SHIFT){lp_q[LPW-1]}},
				lp_q, {swms_pkg::LP_ACC_SHIFT{1'b0}}});
			swms_pkg::ACC_GAIN: acc_q <= acc_q + $signed({prod_q[AW-swms_pkg::GAIN_ACC_SHIFT-1:0],
				{swms_pkg::GAIN_ACC_SHIFT{1'b0}}});
			swms_pkg::ACC_MIX:  acc_q <= acc_q + $signed({{(AW-PW){prod_q[PW-1]}}, prod_q});
		endcase
	end

	assign mid_ext = $signed({{(AW-SDW-swms_pkg::MID_SHIFT){m_q[SDW-1]}}, m_q,
		{swms_pkg::MID_SHIFT{1'b0}}});
	assign sum_l = mid_ext + acc_q + ROUND;
	assign sum_r = mid_ext - acc_q + ROUND;
	assign top_l = sum_l[AW-1:OSH];
	assign top_r = sum_r[AW-1:OSH];
	assign ovf_l = !((&top_l[SUMW-1:SW-1]) || !(|top_l[SUMW-1:SW-1]));
	assign ovf_r = !((&top_r[SUMW-1:SW-1]) || !(|top_r[SUMW-1:SW-1]));
	assign sat_l = ovf_l ? $signed({top_l[SUMW-1], {(SW-1){~top_l[SUMW-1]}}})
		: $signed(top_l[SW-1:0]);
	assign sat_r = ovf_r ? $signed({top_r[SUMW-1], {(SW-1){~top_r[SUMW-1]}}})
		: $signed(top_r[SW-1:0]);

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			left_out  <= sat_l;
			right_out <= sat_r;
			clipped   <= ovf_l || ovf_r;
		end
	end

endmodule

>>> sv/stereo_widener_mid_side.sv
// Top level of the mid/side stereo widener with delayed high side band.
//
// Input channel s_*: one stereo sample pair per item, left and right in
// s_tdata. Output channel m_*: left and right results in m_tdata, the
// saturation flag in m_tuser. Registers are written through cfg_we,
// cfg_index and cfg_wdata only while no item is in flight; not enforced.
//
// Each item runs through a ten-step sequence around one shared 33x17
// multiplier and the single read port of the delay line; a new item is
// taken only once the previous one has left its last step.
//
// After reset the delay line is swept to zero, all 4096 entries, one entry a
// cycle; s_tready stays low during the sweep, register writes are taken.
// When the receiver stalls, the finished result waits in the output
// register; the next item is taken and computed meanwhile and holds in its
// last step until the output register frees up.
module stereo_widener_mid_side (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [swms_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [swms_pkg::CFG_W-1:0]          cfg_wdata,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [swms_pkg::IN_DATA_W-1:0]      s_tdata,   // left_in, right_in
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [swms_pkg::OUT_DATA_W-1:0]     m_tdata,   // left_out, right_out
	output logic                                m_tuser    // clipped
);

	localparam int SW = swms_pkg::SAMPLE_BITS;

	swms_pkg::cmd_t         cmd;
	logic signed [SW-1:0]   left_out, right_out;
	logic                   clipped;

	swms_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	swms_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.left_in   ($signed(s_tdata[SW-1:0])),
		.right_in  ($signed(s_tdata[2*SW-1:SW])),
		.cmd       (cmd),
		.left_out  (left_out),
		.right_out (right_out),
		.clipped   (clipped)
	);

	assign m_tdata = swms_pkg::OUT_DATA_W'({right_out, left_out});
	assign m_tuser = clipped;

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid || m_tready))
		else $error("result loaded over a pending item");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> m_tvalid)
		else $error("loaded result not presented");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second item taken during a step sequence");

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_wr |-> (!s_tready && !cmd.high_wr && !cmd.rd_en))
		else $error("delay line used during clear sweep");

endmodule

>>> bench/swms_check.sv
`timescale 1ns / 1ps
// Checker for the stereo widener: predicts each output pair from the accepted inputs and compares.
module swms_check
	import swms_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_wdata,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // left_in, right_in
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,   // left_out, right_out
	input  logic                  m_tuser,   // clipped
	output int                    mismatches,
	output int                    pending,
	output int                    results,
	output int                    clips
);

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left;
		logic signed [SAMPLE_BITS-1:0] right;
		logic                          clipped;
	} stereo_pair_t;

	localparam longint LINE_SPAN = longint'(DELAY_DEPTH) * 256;
	localparam longint ONE_Q24   = 64'sd16777216;
	localparam int     EXP_DEPTH = 16;

	logic [COEF_W-1:0]  coef_q;
	logic [GAIN_W-1:0]  gain_q;
	logic [MIX_W-1:0]   mix_q;
	logic [DELAY_W-1:0] delay_q;
	longint             side_lp;
	longint             haas_line [DELAY_DEPTH];
	int unsigned        line_wr;
	stereo_pair_t       expected_pairs [EXP_DEPTH];
	int unsigned        exp_wr, exp_rd;

	function automatic longint saturate(input longint v, input int bits, output bit hit);
		longint hi;
		hi = (longint'(1) <<< (bits - 1)) - 1;
		hit = 1'b0;
		if (v > hi) begin
			hit = 1'b1;
			return hi;
		end
		if (v < -hi - 1) begin
			hit = 1'b1;
			return -hi - 1;
		end
		return v;
	endfunction

	// one sample pair through lowpass split, delay line and mid/side recombine
	function automatic stereo_pair_t widen(input logic signed [SAMPLE_BITS-1:0] l,
	                                       input logic signed [SAMPLE_BITS-1:0] r);
		longint       m, d, low, high, pos, frac, dl, s, lo, ro;
		int unsigned  i0, i1;
		bit           hit_h, hit_l, hit_r;
		stereo_pair_t res;
		m = longint'(l) + longint'(r);
		d = longint'(l) - longint'(r);
		side_lp = side_lp + ((longint'(coef_q) * (d * 128 - side_lp)) >>> LP_SHIFT);
		low  = side_lp >>> LP_IN_SHIFT;
		high = saturate(d - low, SIDE_W, hit_h);
		haas_line[line_wr] = high;
		pos  = (longint'(line_wr) * 256 + LINE_SPAN - longint'(delay_q) % LINE_SPAN) % LINE_SPAN;
		i0   = int'(pos >>> FRAC_W);
		frac = pos % 256;
		i1   = (i0 + 1) % DELAY_DEPTH;
		dl   = haas_line[i0] * (256 - frac) + haas_line[i1] * frac;
		line_wr = (line_wr + 1) % DELAY_DEPTH;
		s  = side_lp * 131072 + high * longint'(gain_q) * 1024 + dl * longint'(mix_q);
		lo = saturate((m * ONE_Q24 + s + ONE_Q24) >>> OUT_SHIFT, SAMPLE_BITS, hit_l);
		ro = saturate((m * ONE_Q24 - s + ONE_Q24) >>> OUT_SHIFT, SAMPLE_BITS, hit_r);
		res.left    = lo[SAMPLE_BITS-1:0];
		res.right   = ro[SAMPLE_BITS-1:0];
		res.clipped = hit_l | hit_r;
		return res;
	endfunction

	task automatic compare_field(input string name, input logic signed [63:0] want,
	                             input logic signed [63:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%t: %s expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		stereo_pair_t got, want;
		if (!arst_n) begin
			coef_q  = LOWPASS_COEF_RST;
			gain_q  = WIDTH_GAIN_RST;
			mix_q   = HAAS_MIX_RST;
			delay_q = DELAY_AMOUNT_RST;
			side_lp = 0;
			line_wr = 0;
			foreach (haas_line[i])
				haas_line[i] = 0;
			exp_wr     = 0;
			exp_rd     = 0;
			mismatches = 0;
			pending    = 0;
			results    = 0;
			clips      = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.left    = m_tdata[SAMPLE_BITS-1:0];
				got.right   = m_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
				got.clipped = m_tuser;
				results++;
				if (got.clipped === 1'b1)
					clips++;
				if (exp_wr == exp_rd) begin
					mismatches++;
					$display("%t: unexpected item, expected none, got left %0d right %0d clip %b",
					         $time, got.left, got.right, got.clipped);
				end else begin
					want = expected_pairs[exp_rd % EXP_DEPTH];
					exp_rd++;
					compare_field("left_out", want.left, got.left);
					compare_field("right_out", want.right, got.right);
					compare_field("clipped", want.clipped, got.clipped);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_LOWPASS_COEF: coef_q  = cfg_wdata[COEF_W-1:0];
					REG_WIDTH_GAIN:   gain_q  = cfg_wdata[GAIN_W-1:0];
					REG_HAAS_MIX:     mix_q   = cfg_wdata[MIX_W-1:0];
					REG_DELAY_AMOUNT: delay_q = cfg_wdata[DELAY_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				expected_pairs[exp_wr % EXP_DEPTH] = widen(s_tdata[SAMPLE_BITS-1:0],
				                                           s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);
				exp_wr++;
			end
			pending = int'(exp_wr - exp_rd);
		end
	end

endmodule

>>> bench/tb_stereo_widener_mid_side.sv
`timescale 1ns / 1ps
// Testbench top: drives sample pairs and register writes into the widener and gives the verdict.
module tb_stereo_widener_mid_side;
	import swms_pkg::*;

	localparam int LIMIT = 1_000_000;
	localparam int PHASE_ITEMS = 272;
	localparam logic [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_W-1:0]      cfg_wdata = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;

	int mismatches, pending, results, clips;
	int sent        = 0;
	int settings    = 0;
	int cycles      = 0;
	int hold_asks   = 0;
	int hold_served = 0;
	bit no_idle     = 1'b0;
	bit sq_hi       = 1'b0;
	logic [SAMPLE_BITS-1:0] last_l = '0;
	logic [SAMPLE_BITS-1:0] last_r = '0;

	stereo_widener_mid_side dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	swms_check check_u (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.mismatches (mismatches),
		.pending    (pending),
		.results    (results),
		.clips      (clips)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("timeout after %0d cycles, %0d items still pending", cycles, pending);
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic int idle_gap();
		int pick;
		if (no_idle)
			return 0;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			return 0;
		if (pick < 90)
			return $urandom_range(1, 3);
		if (pick < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] edge_sample();
		case ($urandom_range(0, 4))
			0: return S_MAX;
			1: return S_MIN;
			2: return '0;
			3: return '1;
			default: return SAMPLE_BITS'(1);
		endcase
	endfunction

	task automatic make_pair(output logic [SAMPLE_BITS-1:0] l, output logic [SAMPLE_BITS-1:0] r);
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				l = SAMPLE_BITS'($urandom);
				r = SAMPLE_BITS'($urandom);
			end
			4: begin
				l = SAMPLE_BITS'($urandom_range(0, 511) - 256);
				r = SAMPLE_BITS'($urandom_range(0, 511) - 256);
			end
			5: begin
				l = edge_sample();
				r = edge_sample();
			end
			6: begin
				l = SAMPLE_BITS'($urandom);
				r = l;
			end
			7: begin
				l = SAMPLE_BITS'($urandom);
				r = -l;
			end
			8: begin
				// full-scale side square wave, drives high band and outputs into saturation
				sq_hi = !sq_hi;
				l = sq_hi ? S_MAX : S_MIN;
				r = sq_hi ? S_MIN : S_MAX;
			end
			default: begin
				l = last_l + SAMPLE_BITS'($urandom_range(0, 2047) - 1024);
				r = last_r + SAMPLE_BITS'($urandom_range(0, 2047) - 1024);
			end
		endcase
		last_l = l;
		last_r = r;
	endtask

	// called at a falling edge; returns at a falling edge with valid left high unless a gap follows
	task automatic send_pair(input logic [SAMPLE_BITS-1:0] l, input logic [SAMPLE_BITS-1:0] r);
		int gap;
		s_tdata  <= IN_DATA_W'({r, l});
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sent++;
		@(negedge clk);
		gap = idle_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic settle_block();
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	task automatic load_regs(input logic [CFG_W-1:0] coef, input logic [CFG_W-1:0] gain,
	                         input logic [CFG_W-1:0] mix, input logic [CFG_W-1:0] dly);
		cfg_we    <= 1'b1;
		cfg_index <= REG_LOWPASS_COEF;
		cfg_wdata <= coef;
		@(negedge clk);
		cfg_index <= REG_WIDTH_GAIN;
		cfg_wdata <= gain;
		@(negedge clk);
		cfg_index <= REG_HAAS_MIX;
		cfg_wdata <= mix;
		@(negedge clk);
		cfg_index <= REG_DELAY_AMOUNT;
		cfg_wdata <= dly;
		@(negedge clk);
		cfg_we <= 1'b0;
		settings++;
	endtask

	initial begin : receiver
		int run, stall, pick;
		@(posedge arst_n);
		forever begin
			if (hold_asks != hold_served) begin
				hold_served++;
				m_tready <= 1'b0;
				for (int c = 0; c < 400; c++)
					@(negedge clk);
			end else begin
				m_tready <= 1'b1;
				run = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 20) : $urandom_range(50, 300);
				repeat (run) @(negedge clk);
				pick = $urandom_range(0, 99);
				if (pick < 50)
					stall = 0;
				else if (pick < 92)
					stall = $urandom_range(1, 3);
				else
					stall = $urandom_range(10, 60);
				if (stall > 0) begin
					m_tready <= 1'b0;
					repeat (stall) @(negedge clk);
				end
			end
		end
	end

	initial begin : stimulus
		logic [SAMPLE_BITS-1:0] l, r;
		logic [CFG_W-1:0]       coef, gain, mix, dly;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// extremes under the reset register values
		send_pair('0, '0);
		send_pair(S_MAX, S_MAX);
		send_pair(S_MIN, S_MIN);
		send_pair(S_MAX, S_MIN);
		send_pair(S_MIN, S_MAX);
		send_pair('1, '1);
		send_pair(SAMPLE_BITS'(1), '1);
		send_pair(S_MAX, '0);
		send_pair('0, S_MIN);
		send_pair('1, '0);
		send_pair(SAMPLE_BITS'(1), '0);
		send_pair('0, SAMPLE_BITS'(1));

		// fast lowpass, zero delay, mix written past its width; charge lowpass negative
		settle_block();
		load_regs(20'd65535, 20'd32768, 20'hFFFFF, 20'd0);
		send_pair(S_MIN, S_MAX);
		send_pair(S_MIN, S_MAX);
		send_pair(S_MIN, S_MAX);

		// frozen lowpass so the flipped side overflows the high band; delay wraps past the line
		settle_block();
		load_regs(20'd0, 20'hFFFF, 20'd19661, 20'hFFFFF);
		send_pair(S_MAX, S_MIN);
		send_pair(S_MAX, S_MIN);
		send_pair('0, '0);
		send_pair(S_MAX, S_MAX);
		send_pair(S_MIN, S_MIN);

		for (int ph = 0; ph < 7; ph++) begin
			settle_block();
			case (ph)
				0: begin
					coef = 20'd0;
					gain = 20'd16384;
					mix  = 20'd0;
					dly  = 20'd0;
				end
				1: begin
					coef = 20'd65535;
					gain = 20'd32768;
					mix  = 20'd19661;
					dly  = 20'd1047552;
				end
				2: begin
					coef = 20'hFFFFF;
					gain = 20'hFFFFF;
					mix  = 20'hFFFFF;
					dly  = 20'hFFFFF;
				end
				3: begin
					coef = CFG_W'($urandom_range(0, 65535));
					gain = CFG_W'($urandom_range(16384, 32768));
					mix  = CFG_W'($urandom_range(0, 19661));
					dly  = CFG_W'($urandom_range(0, 1047552));
				end
				4: begin
					coef = CFG_W'($urandom);
					gain = CFG_W'($urandom);
					mix  = CFG_W'($urandom);
					dly  = CFG_W'($urandom);
				end
				5: begin
					coef = CFG_W'($urandom_range(0, 65535));
					gain = CFG_W'($urandom_range(16384, 32768));
					mix  = CFG_W'($urandom_range(0, 19661));
					dly  = CFG_W'($urandom_range(0, 1023));
				end
				default: begin
					coef = 20'd1274;
					gain = 20'd24576;
					mix  = 20'd9830;
					dly  = 20'd61440;
				end
			endcase
			load_regs(coef, gain, mix, dly);
			no_idle = (ph == 2);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (ph == 3 && k == 40)
					hold_asks++;
				if (ph == 1 && k == PHASE_ITEMS / 2)
					settle_block();
				make_pair(l, r);
				send_pair(l, r);
			end
		end

		settle_block();
		$display("Sent %0d sample pairs under %0d register settings (zero, wrapped and fractional",
		         sent, settings);
		$display("delays, frozen and fast lowpass); %0d results checked, %0d clipped.",
		         results, clips);
		if (mismatches == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
